### rtl/rrcpd_pkg.sv
package rrcpd_pkg;

   localparam int DATA_W      = 8;
   localparam int PIX_W       = 16;
   localparam int CNT_W       = 8;
   localparam int COORD_W     = 11;
   localparam int DIM_REG_W   = 12;
   localparam int PAIRS_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DEF_MAX_DIM = 2048;

   // largest dimension the 12-bit registers can hold
   localparam int REG_DIM_MAX = (2 ** DIM_REG_W) - 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_WISE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_CHUNK_RLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_PAIRS     = 3'd4;

   function automatic int dim_limit(int max_dim);
      return (max_dim < REG_DIM_MAX) ? max_dim : REG_DIM_MAX;
   endfunction

   function automatic int dim_width(int max_dim);
      return $clog2(dim_limit(max_dim) + 1);
   endfunction

   // entry that produces a run descriptor, handed from parser to datapath
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [CNT_W-1:0] run_count;
      logic             last_run;
   } seed_type;

   typedef struct packed {
      logic capture;
      logic mul_total;
      logic mul_lin;
      logic clamp;
      logic advance;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [CNT_W-1:0]   run_count;
      logic [COORD_W-1:0] start_column;
      logic [COORD_W-1:0] start_row;
      logic               out_of_bounds;
      logic               last_run;
   } rsp_payload_type;

endpackage

### rtl/rrcpd_req_if.sv
interface rrcpd_req_if;
   logic                             valid;
   logic                             ready;
   logic [rrcpd_pkg::DATA_W-1:0]     data_byte;
   logic                             start_of_image;

   modport source(output valid, output data_byte, output start_of_image, input ready);
   modport sink(input valid, input data_byte, input start_of_image, output ready);
endinterface

### rtl/rrcpd_rsp_if.sv
interface rrcpd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rrcpd_pkg::PIX_W-1:0]       pixel;
   logic [rrcpd_pkg::CNT_W-1:0]       run_count;
   logic [rrcpd_pkg::COORD_W-1:0]     start_column;
   logic [rrcpd_pkg::COORD_W-1:0]     start_row;
   logic                              out_of_bounds;
   logic                              last_run;

   modport source(output valid, output pixel, output run_count, output start_column,
                  output start_row, output out_of_bounds, output last_run, input ready);
   modport sink(input valid, input pixel, input run_count, input start_column,
                input start_row, input out_of_bounds, input last_run, output ready);
endinterface

### rtl/rrcpd_csr_if.sv
interface rrcpd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rrcpd_pkg::CSR_IDX_W-1:0]    index;
   logic [rrcpd_pkg::CSR_DATA_W-1:0]   data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/rrcpd_parser.sv
module rrcpd_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [rrcpd_pkg::DATA_W-1:0]       data_byte,
   input  logic                               start_of_image,
   input  logic                               first_chunk_rle,
   input  logic [rrcpd_pkg::PAIRS_W-1:0]      chunk_pairs,
   output logic                               emit,
   output rrcpd_pkg::seed_type                seed
);

   typedef enum logic [1:0] {
      PH_COUNT,
      PH_RUN,
      PH_LOW,
      PH_HIGH
   } phase_type;

   phase_type                          phase_ff, phase_in, s_phase;
   logic                               rle_ff, rle_in, s_rle;
   logic                               second_ff, second_in, s_second;
   logic [rrcpd_pkg::CNT_W-1:0]        entries_ff, entries_in, s_entries;
   logic [rrcpd_pkg::PAIRS_W-1:0]      pairs_ff, pairs_in, s_pairs;
   logic [rrcpd_pkg::CNT_W-1:0]        run_ff, run_in, s_run;
   logic [rrcpd_pkg::DATA_W-1:0]       low_ff, low_in, s_low;
   logic                               fin_ff, fin_in, s_fin;
   logic [rrcpd_pkg::CNT_W-1:0]        ent_dec;
   logic [rrcpd_pkg::PAIRS_W-1:0]      pairs_dec;
   logic                               final_chunk;
   logic                               chunk_done;

   always_comb begin
      // start of image restarts the parser on this very byte
      if (start_of_image) begin
         s_phase   = PH_COUNT;
         s_rle     = first_chunk_rle;
         s_second  = 1'b0;
         s_entries = '0;
         s_pairs   = chunk_pairs;
         s_run     = '0;
         s_low     = '0;
         s_fin     = (chunk_pairs == '0);
      end else begin
         s_phase   = phase_ff;
         s_rle     = rle_ff;
         s_second  = second_ff;
         s_entries = entries_ff;
         s_pairs   = pairs_ff;
         s_run     = run_ff;
         s_low     = low_ff;
         s_fin     = fin_ff;
      end

      phase_in   = s_phase;
      rle_in     = s_rle;
      second_in  = s_second;
      entries_in = s_entries;
      pairs_in   = s_pairs;
      run_in     = s_run;
      low_in     = s_low;
      fin_in     = s_fin;

      ent_dec     = s_entries - 1'b1;
      pairs_dec   = s_pairs - 1'b1;
      final_chunk = s_second && (s_pairs == rrcpd_pkg::PAIRS_W'(1));
      chunk_done  = 1'b0;
      emit        = 1'b0;
      seed        = '0;

      if (!s_fin) begin
         case (s_phase)
            PH_COUNT: begin
               entries_in = data_byte;
               if (data_byte == '0) begin
                  chunk_done     = 1'b1;
                  emit           = final_chunk;
                  seed.last_run  = final_chunk;
               end else begin
                  phase_in = s_rle ? PH_RUN : PH_LOW;
               end
            end
            PH_RUN: begin
               run_in   = data_byte;
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               low_in   = data_byte;
               phase_in = PH_HIGH;
            end
            PH_HIGH: begin
               entries_in     = ent_dec;
               seed.pixel     = {data_byte, s_low};
               seed.run_count = s_rle ? s_run : rrcpd_pkg::CNT_W'(1);
               seed.last_run  = (ent_dec == '0) && final_chunk;
               if (ent_dec == '0) begin
                  chunk_done = 1'b1;
               end else begin
                  phase_in = s_rle ? PH_RUN : PH_LOW;
               end
               // drop zero runs unless they close the image
               emit = (seed.run_count != '0) || seed.last_run;
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase

         if (chunk_done) begin
            if (s_second) begin
               second_in = 1'b0;
               pairs_in  = pairs_dec;
               if (pairs_dec == '0) begin
                  fin_in = 1'b1;
               end
            end else begin
               second_in = 1'b1;
            end
            rle_in   = ~s_rle;
            phase_in = PH_COUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COUNT;
         rle_ff     <= 1'b0;
         second_ff  <= 1'b0;
         entries_ff <= '0;
         pairs_ff   <= '0;
         run_ff     <= '0;
         low_ff     <= '0;
         fin_ff     <= 1'b1;
      end else if (accept) begin
         phase_ff   <= phase_in;
         rle_ff     <= rle_in;
         second_ff  <= second_in;
         entries_ff <= entries_in;
         pairs_ff   <= pairs_in;
         run_ff     <= run_in;
         low_ff     <= low_in;
         fin_ff     <= fin_in;
      end
   end

endmodule

### rtl/rrcpd_ctrl.sv
module rrcpd_ctrl #(
   parameter int MAX_DIM = rrcpd_pkg::DEF_MAX_DIM
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic                 out_busy,
   output logic                 req_ready,
   output rrcpd_pkg::cmd_type   cmd
);

   localparam int DIM_W  = rrcpd_pkg::dim_width(MAX_DIM);
   localparam int STEP_W = $clog2(DIM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_LIN,
      ST_CLAMP,
      ST_ADV,
      ST_DIV,
      ST_PUT
   } state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  state_ff <= ST_TOTAL;
               end
            end
            ST_TOTAL: state_ff <= ST_LIN;
            ST_LIN:   state_ff <= ST_CLAMP;
            ST_CLAMP: state_ff <= ST_ADV;
            ST_ADV: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(DIM_W - 1)) begin
                  state_ff <= ST_PUT;
               end
            end
            ST_PUT: begin
               // hold until the output register frees up
               if (!out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && go;
      cmd.mul_total = (state_ff == ST_TOTAL);
      cmd.mul_lin   = (state_ff == ST_LIN);
      cmd.clamp     = (state_ff == ST_CLAMP);
      cmd.advance   = (state_ff == ST_ADV);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.commit    = (state_ff == ST_PUT) && !out_busy;
   end

endmodule

### rtl/rrcpd_datapath.sv
module rrcpd_datapath #(
   parameter int MAX_DIM = rrcpd_pkg::DEF_MAX_DIM
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rrcpd_pkg::cmd_type                  cmd,
   input  logic                                pos_clear,
   input  rrcpd_pkg::seed_type                 seed,
   input  logic [rrcpd_pkg::DIM_REG_W-1:0]     image_width,
   input  logic [rrcpd_pkg::DIM_REG_W-1:0]     image_height,
   input  logic                                column_wise,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic                                out_busy,
   output rrcpd_pkg::rsp_payload_type          out_payload
);

   localparam int DIM_MAX = rrcpd_pkg::dim_limit(MAX_DIM);
   localparam int DIM_W   = rrcpd_pkg::dim_width(MAX_DIM);
   localparam int LIN_W   = 2 * DIM_W + 1;

   logic [DIM_W-1:0]              col_ff, row_ff;
   rrcpd_pkg::seed_type           seed_ff;
   logic [LIN_W-1:0]              total_ff, lin_ff, rem_ff, dsh_ff;
   logic [DIM_W-1:0]              quo_ff;
   logic                          oob_ff;
   logic                          out_valid_ff;
   rrcpd_pkg::rsp_payload_type    out_ff;

   logic [DIM_W-1:0]              w_eff, h_eff, span, major, minor;
   logic [LIN_W-1:0]              sum;

   function automatic logic [DIM_W-1:0] eff_dim(logic [rrcpd_pkg::DIM_REG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (int'(v) > DIM_MAX) begin
         return DIM_W'(DIM_MAX);
      end
      return DIM_W'(v);
   endfunction

   always_comb begin
      w_eff = eff_dim(image_width);
      h_eff = eff_dim(image_height);
      span  = column_wise ? h_eff : w_eff;
      major = column_wise ? col_ff : row_ff;
      minor = column_wise ? row_ff : col_ff;
      sum   = lin_ff + LIN_W'(seed_ff.run_count);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seed_ff <= seed;
      end
      if (cmd.mul_total) begin
         total_ff <= LIN_W'(w_eff) * LIN_W'(h_eff);
      end
      if (cmd.mul_lin) begin
         lin_ff <= LIN_W'(major) * LIN_W'(span) + LIN_W'(minor);
      end
      if (cmd.clamp && (lin_ff > total_ff)) begin
         lin_ff <= total_ff;
      end
      if (cmd.advance) begin
         oob_ff <= (sum > total_ff);
         rem_ff <= (sum > total_ff) ? total_ff : sum;
         dsh_ff <= LIN_W'(span) << (DIM_W - 1);
         quo_ff <= '0;
      end
      // one quotient bit per step, most significant first
      if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[DIM_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[DIM_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.commit) begin
         out_ff.pixel         <= seed_ff.pixel;
         out_ff.run_count     <= seed_ff.run_count;
         out_ff.start_column  <= rrcpd_pkg::COORD_W'(col_ff);
         out_ff.start_row     <= rrcpd_pkg::COORD_W'(row_ff);
         out_ff.out_of_bounds <= oob_ff;
         out_ff.last_run      <= seed_ff.last_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pos_clear) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (cmd.commit) begin
            if (column_wise) begin
               col_ff <= quo_ff;
               row_ff <= DIM_W'(rem_ff);
            end else begin
               row_ff <= quo_ff;
               col_ff <= DIM_W'(rem_ff);
            end
         end
         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_busy    = out_valid_ff && !out_ready;
   assign out_payload = out_ff;

endmodule

### rtl/raw_rle_chunk_pixel_decoder.sv
// channel   dir  beat payload
// req_ch    in   data_byte, start_of_image
// rsp_ch    out  pixel, run_count, start_column, start_row, out_of_bounds, last_run
// csr_ch    in   index, data (register write)
//
// A byte that yields no run descriptor leaves the block ready for the next byte. A byte
// that yields one holds off further bytes through two multiplies, clamp, and a restoring
// divider that forms one quotient bit per cycle to rewrap the fill position.
// Reset is synchronous; configuration resets to width 1, height 1, column mode.
// The next byte is taken while a descriptor still waits in the output register;
// a new descriptor holds in the last step until that register is free.
module raw_rle_chunk_pixel_decoder #(
   parameter int MAX_DIM = rrcpd_pkg::DEF_MAX_DIM
) (
   input  logic              clock,
   input  logic              reset,
   rrcpd_req_if.sink         req_ch,
   rrcpd_rsp_if.source       rsp_ch,
   rrcpd_csr_if.sink         csr_ch
);

   logic [rrcpd_pkg::DIM_REG_W-1:0]   width_ff, height_ff;
   logic                              column_wise_ff;
   logic                              first_rle_ff;
   logic [rrcpd_pkg::PAIRS_W-1:0]     pairs_ff;

   logic                              req_ready;
   logic                              accept;
   logic                              emit;
   logic                              out_valid;
   logic                              out_busy;
   rrcpd_pkg::seed_type               seed;
   rrcpd_pkg::cmd_type                cmd;
   rrcpd_pkg::rsp_payload_type        payload;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= rrcpd_pkg::DIM_REG_W'(1);
         height_ff      <= rrcpd_pkg::DIM_REG_W'(1);
         column_wise_ff <= 1'b1;
         first_rle_ff   <= 1'b0;
         pairs_ff       <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            rrcpd_pkg::CSR_IMAGE_WIDTH:     width_ff       <= csr_ch.data[rrcpd_pkg::DIM_REG_W-1:0];
            rrcpd_pkg::CSR_IMAGE_HEIGHT:    height_ff      <= csr_ch.data[rrcpd_pkg::DIM_REG_W-1:0];
            rrcpd_pkg::CSR_COLUMN_WISE:     column_wise_ff <= csr_ch.data[0];
            rrcpd_pkg::CSR_FIRST_CHUNK_RLE: first_rle_ff   <= csr_ch.data[0];
            rrcpd_pkg::CSR_CHUNK_PAIRS:     pairs_ff       <= csr_ch.data[rrcpd_pkg::PAIRS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = req_ready;
   assign accept       = req_ch.valid && req_ready;

   rrcpd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_ch.data_byte),
      .start_of_image  (req_ch.start_of_image),
      .first_chunk_rle (first_rle_ff),
      .chunk_pairs     (pairs_ff),
      .emit            (emit),
      .seed            (seed)
   );

   rrcpd_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .go        (accept && emit),
      .out_busy  (out_busy),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   rrcpd_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .pos_clear    (accept && req_ch.start_of_image),
      .seed         (seed),
      .image_width  (width_ff),
      .image_height (height_ff),
      .column_wise  (column_wise_ff),
      .out_ready    (rsp_ch.ready),
      .out_valid    (out_valid),
      .out_busy     (out_busy),
      .out_payload  (payload)
   );

   assign rsp_ch.valid         = out_valid;
   assign rsp_ch.pixel         = payload.pixel;
   assign rsp_ch.run_count     = payload.run_count;
   assign rsp_ch.start_column  = payload.start_column;
   assign rsp_ch.start_row     = payload.start_row;
   assign rsp_ch.out_of_bounds = payload.out_of_bounds;
   assign rsp_ch.last_run      = payload.last_run;

endmodule
